// ===== hw/rtl/ssd_pkg.sv =====
// Shared types, constants and pattern lookups for the seven-segment serial driver.
// No dependencies; imported by ssd_front, ssd_fifo, ssd_back and the top level.
package ssd_pkg;

    localparam int BITS_PER_BYTE  = 8;
    localparam int DIGIT_COUNT    = 4;
    localparam int MODE_W         = 2;
    localparam int POS_W          = 2;
    localparam int VALUE_W        = 14;
    localparam int CHAR_W         = 8;
    localparam int FRAME_W        = 2 * BITS_PER_BYTE;
    localparam int BCD_W          = 4 * DIGIT_COUNT;
    localparam int STEP_W         = $clog2(VALUE_W);
    localparam int BIT_CNT_W      = $clog2(FRAME_W);
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [VALUE_W-1:0]       MAX_NUMBER    = VALUE_W'(9999);
    localparam logic [VALUE_W-1:0]       MAX_DIGIT     = VALUE_W'(9);
    localparam logic [BITS_PER_BYTE-1:0] BLANK_PATTERN = 8'hFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_DIGIT  = 2'd0,
        MODE_CHAR   = 2'd1,
        MODE_BLANK  = 2'd2,
        MODE_NUMBER = 2'd3
    } t_mode;

    // one queued frame: segment pattern, display position, last frame of item
    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] pattern;
        logic [POS_W-1:0]         position;
        logic                     last;
    } t_frame;

    // active-low segment patterns for decimal digits
    function automatic logic [BITS_PER_BYTE-1:0] f_digit_pattern(input logic [3:0] d);
        logic [BITS_PER_BYTE-1:0] p;
        case (d)
            4'd0:    p = 8'hC0;
            4'd1:    p = 8'hF9;
            4'd2:    p = 8'hA4;
            4'd3:    p = 8'hB0;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h92;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'hF8;
            4'd8:    p = 8'h80;
            4'd9:    p = 8'h90;
            default: p = BLANK_PATTERN;
        endcase
        return p;
    endfunction

    // active-low segment patterns for letters A..Z
    function automatic logic [BITS_PER_BYTE-1:0] f_letter_pattern(input logic [4:0] idx);
        logic [BITS_PER_BYTE-1:0] p;
        case (idx)
            5'd0:    p = 8'h88;
            5'd1:    p = 8'h83;
            5'd2:    p = 8'hC6;
            5'd3:    p = 8'hA1;
            5'd4:    p = 8'h86;
            5'd5:    p = 8'h8E;
            5'd6:    p = 8'hC2;
            5'd7:    p = 8'h89;
            5'd8:    p = 8'hCF;
            5'd9:    p = 8'hE1;
            5'd10:   p = 8'h8A;
            5'd11:   p = 8'hC7;
            5'd12:   p = 8'hEA;
            5'd13:   p = 8'hC8;
            5'd14:   p = 8'hC0;
            5'd15:   p = 8'h8C;
            5'd16:   p = 8'h4A;
            5'd17:   p = 8'hCC;
            5'd18:   p = 8'h92;
            5'd19:   p = 8'h87;
            5'd20:   p = 8'hC1;
            5'd21:   p = 8'hC1;
            5'd22:   p = 8'hD5;
            5'd23:   p = 8'h89;
            5'd24:   p = 8'h91;
            5'd25:   p = 8'hA4;
            default: p = BLANK_PATTERN;
        endcase
        return p;
    endfunction

    // ASCII to pattern; both letter cases share bits [4:0], anything else blanks
    function automatic logic [BITS_PER_BYTE-1:0] f_char_pattern(input logic [CHAR_W-1:0] c);
        logic [4:0]               idx;
        logic [BITS_PER_BYTE-1:0] p;
        idx = c[4:0] - 5'd1;
        if (c[7:6] == 2'b01 && c[4:0] != 5'd0 && c[4:0] <= 5'd26) begin
            p = f_letter_pattern(idx);
        end else begin
            p = BLANK_PATTERN;
        end
        return p;
    endfunction

    // digit-select byte: high nibble set, one-hot low nibble per position
    function automatic logic [BITS_PER_BYTE-1:0] f_select(input logic [POS_W-1:0] pos);
        return 8'hF0 | (8'd1 << pos);
    endfunction

endpackage

// ===== hw/rtl/ssd_front.sv =====
// Front end: accepts input beats, classifies the mode and queues frames.
// Number mode converts to BCD one bit per cycle (shift-add-3). Uses ssd_pkg.
module ssd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ssd_pkg::MODE_W-1:0]    i_mode,
    input  logic [ssd_pkg::POS_W-1:0]     i_position,
    input  logic [ssd_pkg::VALUE_W-1:0]   i_value,
    input  logic [ssd_pkg::CHAR_W-1:0]    i_character,
    output logic                          o_push,
    output ssd_pkg::t_frame               o_frame,
    input  logic                          i_full
);
    import ssd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} t_state;

    t_state                  r_state;
    logic [STEP_W-1:0]       r_step;
    logic [VALUE_W-1:0]      r_bin;
    logic [BCD_W-1:0]        r_bcd;
    logic [POS_W-1:0]        r_idx;

    logic                     w_accept;
    logic                     w_single_ok;
    logic                     w_number_ok;
    logic [BITS_PER_BYTE-1:0] w_single_pat;
    logic [BCD_W-1:0]         w_adj;

    assign o_ready  = (r_state == S_IDLE) && !i_full;
    assign w_accept = i_valid && o_ready;

    // classify a single-frame beat
    always_comb begin
        w_single_ok  = 1'b0;
        w_single_pat = BLANK_PATTERN;
        w_number_ok  = 1'b0;
        case (t_mode'(i_mode))
            MODE_DIGIT: begin
                w_single_ok  = (i_value <= MAX_DIGIT);
                w_single_pat = f_digit_pattern(i_value[3:0]);
            end
            MODE_CHAR: begin
                w_single_ok  = 1'b1;
                w_single_pat = f_char_pattern(i_character);
            end
            MODE_BLANK: begin
                w_single_ok  = 1'b1;
                w_single_pat = BLANK_PATTERN;
            end
            MODE_NUMBER: begin
                w_number_ok  = (i_value <= MAX_NUMBER);
            end
            default: begin
                w_single_ok  = 1'b0;
            end
        endcase
    end

    // add-3 correction on every BCD digit of five or more
    always_comb begin
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                        : r_bcd[4*d +: 4];
        end
    end

    // queue write: one frame per beat, or four digit frames for a number
    always_comb begin
        if (r_state == S_EMIT) begin
            o_push           = !i_full;
            o_frame.pattern  = f_digit_pattern(r_bcd[BCD_W-1 -: 4]);
            o_frame.position = r_idx;
            o_frame.last     = (r_idx == POS_W'(DIGIT_COUNT - 1));
        end else begin
            o_push           = (r_state == S_IDLE) && w_accept && w_single_ok;
            o_frame.pattern  = w_single_pat;
            o_frame.position = i_position;
            o_frame.last     = 1'b1;
        end
    end

    // sequencer: idle, binary-to-BCD steps, digit frame emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_number_ok) begin
                        r_bin   <= i_value;
                        r_bcd   <= '0;
                        r_step  <= STEP_W'(VALUE_W - 1);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                    r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                    if (r_step == '0) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_step  <= r_step - 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!i_full) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == POS_W'(DIGIT_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted in-range number always starts a conversion
    a_number_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && t_mode'(i_mode) == MODE_NUMBER && i_value <= MAX_NUMBER)
        |=> (r_state == S_CONV))
        else $error("number beat did not start conversion");

    // nothing is queued while converting
    a_conv_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> !o_push)
        else $error("frame queued during conversion");

endmodule

// ===== hw/rtl/ssd_fifo.sv =====
// Short frame queue between front and back ends.
// Register array with read and write pointers. Uses ssd_pkg for the frame type.
module ssd_fifo #(
    parameter int DEPTH = ssd_pkg::FIFO_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ssd_pkg::t_frame i_frame,
    output logic            o_full,
    input  logic            i_pop,
    output ssd_pkg::t_frame o_frame,
    output logic            o_empty
);
    import ssd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_frame = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");

endmodule

// ===== hw/rtl/ssd_back.sv =====
// Back end: serializes queued frames MSB first, one bit per output beat.
// The shift register doubles as the output register. Uses ssd_pkg.
module ssd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ssd_pkg::t_frame i_frame,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_data_bit,
    output logic            o_frame_end,
    output logic            o_last_of_run
);
    import ssd_pkg::*;

    logic                   r_busy;
    logic [FRAME_W-1:0]     r_shift;
    logic [BIT_CNT_W-1:0]   r_cnt;
    logic                   r_last;

    logic                   w_done;
    logic                   w_free;

    assign o_valid       = r_busy;
    assign o_data_bit    = r_shift[FRAME_W-1];
    assign o_frame_end   = (r_cnt == BIT_CNT_W'(FRAME_W - 1));
    assign o_last_of_run = o_frame_end && r_last;

    // load the next frame as the last bit of the current one leaves
    assign w_done = r_busy && i_ready && o_frame_end;
    assign w_free = !r_busy || w_done;
    assign o_pop  = w_free && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_pop) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
            r_shift <= {i_frame.pattern, f_select(i_frame.position)};
            r_last  <= i_frame.last;
        end else if (w_done) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else if (r_busy && i_ready) begin
            r_shift <= {r_shift[FRAME_W-2:0], 1'b0};
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    // run end only ever falls on a frame end
    a_run_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_run |-> o_frame_end)
        else $error("run end off frame boundary");

    // queued frames follow without a gap
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_frame_end && !i_empty) |=> o_valid && (r_cnt == '0))
        else $error("bubble between queued frames");

endmodule

// ===== hw/rtl/seven_segment_serial_driver.sv =====
// Four-digit seven-segment serial driver, top level. Uses ssd_pkg, ssd_front, ssd_fifo, ssd_back.
// A single-frame item is one 16-bit frame, a number four. The serial output moves one bit a
// cycle while i_ready is high, and the front end's 14-step BCD conversion overlaps the previous
// item's bits. Frames pass through the queue into the back end's shift register.
// Reset: synchronous, active low; clears the sequencer, the queue pointers and the output valid.
module seven_segment_serial_driver #(
    parameter int FIFO_DEPTH = ssd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ssd_pkg::MODE_W-1:0]    i_mode,
    input  logic [ssd_pkg::POS_W-1:0]     i_position,
    input  logic [ssd_pkg::VALUE_W-1:0]   i_value,
    input  logic [ssd_pkg::CHAR_W-1:0]    i_character,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_data_bit,
    output logic                          o_frame_end,
    output logic                          o_last_of_run
);
    import ssd_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    t_frame w_wr_frame;
    t_frame w_rd_frame;

    ssd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_character (i_character),
        .o_push      (w_push),
        .o_frame     (w_wr_frame),
        .i_full      (w_full)
    );

    ssd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_wr_frame),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_frame (w_rd_frame),
        .o_empty (w_empty)
    );

    ssd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_frame       (w_rd_frame),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_bit    (o_data_bit),
        .o_frame_end   (o_frame_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== sim/seven_segment_serial_driver_tb.sv =====
// Self-checking testbench for the seven-segment serial driver: directed and random display
// requests, bursty input, patterned output stalls, bit-by-bit frame prediction.
// Depends on ssd_pkg and seven_segment_serial_driver.
`timescale 1ns / 100ps

module seven_segment_serial_driver_tb;
    import ssd_pkg::*;

    // active-low segment glyphs, digits 0..9 and letters A..Z
    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };
    localparam logic [7:0] LETTER_GLYPH [26] = '{
        8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hCF, 8'hE1,
        8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h4A, 8'hCC, 8'h92, 8'h87,
        8'hC1, 8'hC1, 8'hD5, 8'h89, 8'h91, 8'hA4
    };
    localparam int LIT_ITEMS   = 430;
    localparam int DRAIN_TICKS = 40;

    // one serial beat as it leaves the block
    typedef struct packed {
        logic data_bit;
        logic frame_end;
        logic last_of_run;
    } serial_beat_t;

    // Expected serial stream and the frame builder that feeds it
    class segment_scoreboard;
        serial_beat_t pending_bits [$];
        int unsigned  mismatches = 0;

        function logic [7:0] char_glyph(logic [7:0] c);
            if (c >= "A" && c <= "Z") return LETTER_GLYPH[c - "A"];
            if (c >= "a" && c <= "z") return LETTER_GLYPH[c - "a"];
            return BLANK_PATTERN;
        endfunction

        // queue the bits caused by one accepted request, return how many
        function int note_item(t_mode m, logic [1:0] pos, logic [13:0] val, logic [7:0] c);
            logic [7:0]   glyph [4];
            logic [1:0]   slot [4];
            logic [15:0]  word;
            int           n_frames;
            int           place;
            serial_beat_t b;
            n_frames = 0;
            case (m)
                MODE_DIGIT: begin
                    if (val <= 14'd9) begin
                        glyph[0] = DIGIT_GLYPH[val];
                        slot[0]  = pos;
                        n_frames = 1;
                    end
                end
                MODE_CHAR: begin
                    glyph[0] = char_glyph(c);
                    slot[0]  = pos;
                    n_frames = 1;
                end
                MODE_BLANK: begin
                    glyph[0] = BLANK_PATTERN;
                    slot[0]  = pos;
                    n_frames = 1;
                end
                default: begin
                    // thousands down to ones, left to right
                    if (val <= 14'd9999) begin
                        place = 1000;
                        for (int k = 0; k < 4; k++) begin
                            glyph[k] = DIGIT_GLYPH[(int'(val) / place) % 10];
                            slot[k]  = 2'(k);
                            place    = place / 10;
                        end
                        n_frames = 4;
                    end
                end
            endcase
            for (int f = 0; f < n_frames; f++) begin
                word = {glyph[f], 8'hF0 | (8'd1 << slot[f])};
                for (int i = 15; i >= 0; i--) begin
                    b.data_bit    = word[i];
                    b.frame_end   = (i == 0);
                    b.last_of_run = (i == 0) && (f == n_frames - 1);
                    pending_bits.push_back(b);
                end
            end
            return n_frames * 16;
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_bit(serial_beat_t got);
            serial_beat_t want;
            if (pending_bits.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual %b", $time, got);
                mismatches++;
                return;
            end
            want = pending_bits.pop_front();
            compare_field("data_bit", want.data_bit, got.data_bit);
            compare_field("frame_end", want.frame_end, got.frame_end);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return pending_bits.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode      = MODE_DIGIT;
    logic [1:0]  i_position  = '0;
    logic [13:0] i_value     = '0;
    logic [7:0]  i_character = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic        o_data_bit;
    logic        o_frame_end;
    logic        o_last_of_run;

    segment_scoreboard sb = new;
    int          burst_left     = 0;
    logic [15:0] ready_mask     = 16'hFFFF;
    int          ready_run_left = 0;

    seven_segment_serial_driver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_character   (i_character),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_bit    (o_data_bit),
        .o_frame_end   (o_frame_end),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: rotating ready mask, reloaded now and then; some runs never stall
    always @(posedge i_clk) begin
        if (ready_run_left == 0) begin
            ready_mask     = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0101);
            ready_run_left = $urandom_range(50, 400);
        end else begin
            ready_mask = {ready_mask[14:0], ready_mask[15]};
            ready_run_left--;
        end
        i_ready <= ready_mask[15];
    end

    // Output beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_bit('{o_data_bit, o_frame_end, o_last_of_run});
        end
    end

    // Present one request, hold it until taken, then maybe open a gap
    task automatic send_item(input t_mode m, input logic [1:0] pos, input logic [13:0] val,
                             input logic [7:0] c, output int n_bits);
        i_valid     <= 1'b1;
        i_mode      <= m;
        i_position  <= pos;
        i_value     <= val;
        i_character <= c;
        do @(posedge i_clk); while (!o_ready);
        n_bits = sb.note_item(m, pos, val, c);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        int          n_bits;
        int          lit_count;
        int          sel;
        t_mode       m;
        logic [1:0]  pos;
        logic [13:0] val;
        logic [7:0]  c;
        lit_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every digit, out-of-range values, letter edges, blanks, numbers
        for (int d = 0; d < 10; d++) begin
            send_item(MODE_DIGIT, 2'(d), 14'(d), 8'($urandom), n_bits);
        end
        send_item(MODE_DIGIT, 2'd1, 14'd10, 8'($urandom), n_bits);
        send_item(MODE_DIGIT, 2'd2, 14'h3FFF, 8'hFF, n_bits);
        send_item(MODE_CHAR, 2'd0, 14'($urandom), "A", n_bits);
        send_item(MODE_CHAR, 2'd3, 14'($urandom), "z", n_bits);
        send_item(MODE_CHAR, 2'd1, 14'($urandom), "Q", n_bits);
        send_item(MODE_CHAR, 2'd2, 14'($urandom), "@", n_bits);
        send_item(MODE_CHAR, 2'd0, 14'($urandom), "{", n_bits);
        send_item(MODE_CHAR, 2'd3, 14'($urandom), 8'hFF, n_bits);
        send_item(MODE_BLANK, 2'd3, 14'h3FFF, 8'hFF, n_bits);
        send_item(MODE_NUMBER, 2'd3, 14'd0, 8'($urandom), n_bits);
        send_item(MODE_NUMBER, 2'd0, 14'd9999, 8'($urandom), n_bits);
        send_item(MODE_NUMBER, 2'd1, 14'd10000, 8'($urandom), n_bits);
        send_item(MODE_NUMBER, 2'd2, 14'h3FFF, 8'($urandom), n_bits);
        send_item(MODE_NUMBER, 2'd1, 14'd5678, 8'($urandom), n_bits);

        // random: mostly well-formed requests, some junk characters and out-of-range values
        while (lit_count < LIT_ITEMS) begin
            sel = $urandom_range(0, 99);
            pos = 2'($urandom);
            val = 14'($urandom);
            c   = 8'($urandom);
            if (sel < 35) begin
                m   = MODE_NUMBER;
                val = 14'($urandom_range(0, 9999));
            end else if (sel < 55) begin
                m = MODE_CHAR;
                c = 8'($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
            end else if (sel < 75) begin
                m   = MODE_DIGIT;
                val = 14'($urandom_range(0, 9));
            end else if (sel < 85) begin
                m = MODE_BLANK;
            end else if (sel < 93) begin
                m = MODE_CHAR;
            end else begin
                m = $urandom_range(0, 1) ? MODE_DIGIT : MODE_NUMBER;
            end
            send_item(m, pos, val, c, n_bits);
            if (n_bits > 0) lit_count++;
        end
        i_valid <= 1'b0;

        // drain, then watch for stray beats
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_front.sv
hw/rtl/ssd_fifo.sv
hw/rtl/ssd_back.sv
hw/rtl/seven_segment_serial_driver.sv
sim/seven_segment_serial_driver_tb.sv
